// ===== src/lfia_pkg.sv =====
// Shared types and codes for the lowest free identifier allocator.
package lfia_pkg;

  localparam int unsigned ID_FIELD_W = 10;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned BIT_IDX_W  = 5;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_NONE_FREE     = 2'd1,
    ST_OUT_OF_RANGE  = 2'd2,
    ST_NOT_ALLOCATED = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [ID_FIELD_W-1:0] release_id;
  } in_word_t;

  typedef struct packed {
    logic [ID_FIELD_W-1:0] granted_id;
    status_t               status;
  } out_word_t;

  typedef enum logic {
    CTL_IDLE = 1'b0,
    CTL_EXEC = 1'b1
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch input word, launch bitmap word read
    logic exec;   // resolve request, write back, load result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;  // result register full and stalled
  } dp_stat_t;

endpackage

// ===== src/lfia_ctrl.sv =====
// Two-state controller sequencing one request through the datapath.
module lfia_ctrl
  import lfia_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CTL_IDLE: begin
        if (in_valid) state_nxt = CTL_EXEC;
      end
      CTL_EXEC: begin
        if (!stat.out_busy) state_nxt = CTL_IDLE;
      end
      default: state_nxt = CTL_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    case (state_r)
      CTL_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      CTL_EXEC: begin
        cmd.exec = !stat.out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/lfia_dp.sv =====
// Bitmap memory, nonzero-word summary, bump pointer and result register.
module lfia_dp
  import lfia_pkg::*;
#(
  parameter int unsigned MAX_IDS  = 1024,
  parameter int unsigned FIRST_ID = 3
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int unsigned WORDS  = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned BUMP_W = $clog2(MAX_IDS + 1);
  localparam int unsigned CMP_W  = (WIDX_W + 6 > ID_FIELD_W) ? WIDX_W + 6 : ID_FIELD_W;

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     summary_r;
  logic [BUMP_W-1:0]    bump_r;

  // request latched at load
  opcode_t              op_r;
  logic [CMP_W-1:0]     id_r;
  logic [WIDX_W-1:0]    widx_r;
  logic                 hit_r;
  logic                 wvalid_r;
  logic [WORD_BITS-1:0] rdata_r;

  logic                 out_valid_r;
  out_word_t            out_word_r;

  // first nonzero word
  logic              sum_hit;
  logic [WIDX_W-1:0] sum_idx;
  always_comb begin
    sum_hit = 1'b0;
    sum_idx = '0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if (summary_r[i]) begin
        sum_hit = 1'b1;
        sum_idx = WIDX_W'(i);
      end
    end
  end

  logic [CMP_W-1:0]  in_id_ext;
  logic [WIDX_W-1:0] rd_idx;
  assign in_id_ext = CMP_W'(in_word.release_id);
  assign rd_idx    = (in_word.opcode == OP_ALLOC) ? sum_idx
                                                  : in_id_ext[WIDX_W+BIT_IDX_W-1:BIT_IDX_W];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_word.opcode;
      id_r     <= in_id_ext;
      widx_r   <= rd_idx;
      hit_r    <= sum_hit;
      wvalid_r <= summary_r[rd_idx];
      rdata_r  <= mem[rd_idx];
    end
  end

  // a word whose summary bit is clear holds no released id
  logic [WORD_BITS-1:0] word;
  assign word = wvalid_r ? rdata_r : '0;

  logic [BIT_IDX_W-1:0] low_bit;
  always_comb begin
    low_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word[i]) low_bit = BIT_IDX_W'(i);
    end
  end

  logic [BIT_IDX_W-1:0] id_bit;
  logic [WORD_BITS-1:0] rel_mask;
  logic [WORD_BITS-1:0] alloc_mask;
  logic [CMP_W-1:0]     reuse_id;
  logic [CMP_W-1:0]     bump_ext;
  assign id_bit     = id_r[BIT_IDX_W-1:0];
  assign rel_mask   = WORD_BITS'(1) << id_bit;
  assign alloc_mask = WORD_BITS'(1) << low_bit;
  assign reuse_id   = CMP_W'({widx_r, low_bit});
  assign bump_ext   = CMP_W'(bump_r);

  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  logic                 sum_wr;
  logic                 sum_val;
  logic                 bump_inc;
  logic [CMP_W-1:0]     grant;
  status_t              st;

  always_comb begin
    wr_en    = 1'b0;
    wr_data  = word;
    sum_wr   = 1'b0;
    sum_val  = 1'b0;
    bump_inc = 1'b0;
    grant    = '0;
    st       = ST_OK;
    if (op_r == OP_ALLOC) begin
      if (hit_r) begin
        wr_en   = 1'b1;
        wr_data = word & ~alloc_mask;
        sum_wr  = 1'b1;
        sum_val = |(word & ~alloc_mask);
        grant   = reuse_id;
      end else if (bump_ext >= CMP_W'(MAX_IDS)) begin
        st = ST_NONE_FREE;
      end else begin
        grant    = bump_ext;
        bump_inc = 1'b1;
      end
    end else begin
      if (id_r >= bump_ext) begin
        st = ST_OUT_OF_RANGE;
      end else if (id_r < CMP_W'(FIRST_ID) || (word & rel_mask) != '0) begin
        st = ST_NOT_ALLOCATED;
      end else begin
        wr_en   = 1'b1;
        wr_data = word | rel_mask;
        sum_wr  = 1'b1;
        sum_val = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[widx_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      summary_r <= '0;
      bump_r    <= BUMP_W'(FIRST_ID);
    end else if (cmd.exec) begin
      if (sum_wr) summary_r[widx_r] <= sum_val;
      if (bump_inc) bump_r <= BUMP_W'(bump_r + 1'b1);
    end
  end

  logic out_valid_nxt;
  assign out_valid_nxt = cmd.exec | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_word_r.granted_id <= grant[ID_FIELD_W-1:0];
      out_word_r.status     <= st;
    end
  end

  assign stat.out_busy = out_valid_r & out_stall;
  assign out_valid     = out_valid_r;
  assign out_word      = out_word_r;

endmodule

// ===== src/lowest_free_id_allocator.sv =====
// Top level of the lowest free identifier allocator.
// Usage:
//   Input channel (in_valid / in_stall / in_word): a word is an opcode and
//   a release_id. Allocate hands out the lowest released id, else the bump
//   pointer (starting at FIRST_ID); release marks an issued id as free.
//   Result channel (out_valid / out_stall / out_word): one word per request
//   carrying granted_id (0 unless an allocate succeeds) and a status code.
// Sequence:
//   The accept edge latches a request, reads the summary first-set encoder
//   and launches one bitmap word read; the exec edge, once the result
//   register is free, does the in-word first-set search, writes the word
//   back and loads the result register, raising out_valid. No new request
//   is taken until then, set by the single-port bitmap read-modify-write.
// Reset (rst_n low, synchronous): no id released, bump pointer = FIRST_ID,
//   result register empty. Bitmap RAM content is don't-care; the summary
//   flops mark every word empty, so no clearing pass is needed.
// Stall: a stalled result holds in the output register; the block can
//   still take one more request and parks it until the register frees.
module lowest_free_id_allocator
  import lfia_pkg::*;
#(
  parameter int unsigned MAX_IDS  = 1024,
  parameter int unsigned FIRST_ID = 3
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing: IDLE accepts, EXEC resolves once the result slot is free
  lfia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // bitmap, summary, bump pointer, result register
  lfia_dp #(
    .MAX_IDS  (MAX_IDS),
    .FIRST_ID (FIRST_ID)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // load and resolve never fire together
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.exec))
    else $error("load and exec asserted together");

  // an accepted request blocks the input until it is resolved
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not blocked after accept");

  // resolving a request always presents a result next cycle
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("result missing after exec");

  // failed requests carry no identifier
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status != ST_OK) |-> (out_word.granted_id == '0))
    else $error("nonzero id on failed request");

endmodule

// ===== dv/tb_lowest_free_id_allocator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the lowest free identifier allocator.
module tb_lowest_free_id_allocator
  import lfia_pkg::*;
();

  localparam int unsigned MAX_IDS     = 1024;
  localparam int unsigned FIRST_ID    = 3;
  localparam int unsigned ID_TOP      = (1 << ID_FIELD_W) - 1;
  localparam int          RANDOM_WORDS = 1450;
  localparam int          QUIET_TAIL  = 100;   // last words run with no idling
  localparam int          DRAIN_CYCLES = 10;   // idle margin after the last expected result
  localparam int          CYCLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  lowest_free_id_allocator #(
    .MAX_IDS (MAX_IDS),
    .FIRST_ID(FIRST_ID)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow allocator: our own copy of the released bitmap and bump pointer.
  // Updated at the edge a request word is accepted, so the stimulus built
  // for the next word always sees the current allocation state.
  // ---------------------------------------------------------------------------
  bit [MAX_IDS-1:0] shadow_released;
  int unsigned      shadow_bump;

  // Expected result words, oldest first.
  out_word_t grant_q[$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  bit  quiet          = 1'b0;  // no idling on either side once set
  int  stall_left     = 0;

  // Compute the result of one request and advance the shadow state.
  function automatic out_word_t resolve_request(in_word_t w);
    out_word_t   r;
    int          hit;
    int unsigned lim;
    r.granted_id = '0;
    r.status     = ST_OK;
    hit          = -1;
    lim          = (shadow_bump < MAX_IDS) ? shadow_bump : MAX_IDS;
    if (w.opcode == OP_ALLOC) begin
      // lowest released id wins over the bump pointer
      for (int i = 0; i < lim && hit < 0; i++)
        if (shadow_released[i]) hit = i;
      if (hit >= 0) begin
        shadow_released[hit] = 1'b0;
        r.granted_id = ID_FIELD_W'(hit);
      end else if (shadow_bump >= MAX_IDS) begin
        r.status = ST_NONE_FREE;
      end else begin
        r.granted_id = ID_FIELD_W'(shadow_bump);
        shadow_bump++;
      end
    end else begin
      if (w.release_id >= shadow_bump || w.release_id >= MAX_IDS) begin
        r.status = ST_OUT_OF_RANGE;
      end else if (w.release_id < FIRST_ID || shadow_released[w.release_id]) begin
        // reserved ids and double releases leave the state alone
        r.status = ST_NOT_ALLOCATED;
      end else begin
        shadow_released[w.release_id] = 1'b1;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Words change at the falling edge; acceptance is judged at
  // the rising edge from in_stall, which the block only moves after the edge.
  // A random idle gap may precede a word.
  // ---------------------------------------------------------------------------
  task automatic issue_request(input in_word_t w, input bit pinned,
                               input out_word_t pinned_result);
    int        gap;
    out_word_t predicted;
    gap = 0;
    if (!quiet && $urandom_range(3, 0) == 0) gap = $urandom_range(11, 1);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    predicted = resolve_request(w);
    grant_q.push_back(pinned ? pinned_result : predicted);
  endtask

  // Random request shaped by the current shadow state. Most releases target
  // an id already issued; the rest are noise over the whole field.
  function automatic in_word_t pick_request(int alloc_pct, int noise_pct);
    in_word_t w;
    w.release_id = ID_FIELD_W'($urandom_range(ID_TOP, 0));  // don't care on allocate
    if ($urandom_range(99, 0) < alloc_pct) begin
      w.opcode = OP_ALLOC;
    end else begin
      w.opcode = OP_RELEASE;
      if ($urandom_range(99, 0) >= noise_pct && shadow_bump > FIRST_ID)
        w.release_id = ID_FIELD_W'($urandom_range(shadow_bump - 1, FIRST_ID));
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: out_stall in random bursts.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else if (!quiet && rst_n && $urandom_range(5, 0) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(11, 1) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker: every accepted word against the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        $error("unexpected result word: granted_id %0d status %0d",
               out_word.granted_id, out_word.status);
        mismatch_count++;
      end else begin
        want = grant_q.pop_front();
        if (out_word.granted_id !== want.granted_id) begin
          $error("granted_id mismatch: expected %0d, actual %0d",
                 want.granted_id, out_word.granted_id);
          mismatch_count++;
        end
        if (out_word.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 want.status, out_word.status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Directed table. Rows with a pinned result carry the obvious answer
  // (reserved ids, out of range, a double release, first grants off the bump pointer);
  // the rest are checked by the shadow allocator.
  // ---------------------------------------------------------------------------
  typedef struct {
    in_word_t  req;
    bit        pinned;
    out_word_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_row(opcode_t op, int unsigned id, bit pinned,
                                  int unsigned gid, status_t st);
    dir_row_t row;
    row.req.opcode      = op;
    row.req.release_id  = ID_FIELD_W'(id);
    row.pinned          = pinned;
    row.want.granted_id = ID_FIELD_W'(gid);
    row.want.status     = st;
    dir_rows.push_back(row);
  endfunction

  initial begin
    in_word_t w;
    int       sent;
    int       tail_len;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    shadow_released = '0;
    shadow_bump     = FIRST_ID;

    // after reset: nothing issued, bump pointer at FIRST_ID
    add_row(OP_RELEASE, 0,      1, 0, ST_NOT_ALLOCATED);  // reserved, lowest id
    add_row(OP_RELEASE, 2,      1, 0, ST_NOT_ALLOCATED);  // reserved, highest
    add_row(OP_RELEASE, ID_TOP, 1, 0, ST_OUT_OF_RANGE);   // field all ones
    add_row(OP_RELEASE, 3,      1, 0, ST_OUT_OF_RANGE);   // equal to bump pointer
    add_row(OP_ALLOC,   ID_TOP, 1, 3, ST_OK);             // release_id ignored
    add_row(OP_ALLOC,   0,      1, 4, ST_OK);
    add_row(OP_ALLOC,   0,      1, 5, ST_OK);
    add_row(OP_RELEASE, 5,      0, 0, ST_OK);
    add_row(OP_RELEASE, 5,      1, 0, ST_NOT_ALLOCATED);  // double release
    add_row(OP_RELEASE, 4,      0, 0, ST_OK);
    add_row(OP_RELEASE, 3,      0, 0, ST_OK);
    add_row(OP_ALLOC,   0,      0, 0, ST_OK);             // reuses lowest released
    add_row(OP_ALLOC,   0,      0, 0, ST_OK);
    add_row(OP_RELEASE, 6,      1, 0, ST_OUT_OF_RANGE);
    add_row(OP_ALLOC,   0,      0, 0, ST_OK);             // last released
    add_row(OP_ALLOC,   0,      0, 0, ST_OK);             // back to bump pointer
    add_row(OP_RELEASE, 1,      1, 0, ST_NOT_ALLOCATED);
    add_row(OP_RELEASE, 512,    1, 0, ST_OUT_OF_RANGE);
    add_row(OP_RELEASE, 6,      0, 0, ST_OK);
    add_row(OP_ALLOC,   ID_TOP, 0, 0, ST_OK);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      issue_request(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].want);

    // phase 1: mixed traffic while the id space is mostly empty
    sent = 0;
    repeat (300) begin
      issue_request(pick_request(60, 20), 1'b0, '0);
      sent++;
    end

    // phase 2: allocate until every id is out, then run into exhaustion
    while (shadow_bump < MAX_IDS || shadow_released != '0) begin
      w = pick_request(100, 0);
      issue_request(w, 1'b0, '0);
      sent++;
    end
    repeat (4) begin
      issue_request(pick_request(100, 0), 1'b0, '0);
      sent++;
    end

    // phase 3: churn at full occupancy; the tail runs back to back
    tail_len = (RANDOM_WORDS - sent > 150) ? RANDOM_WORDS - sent : 150;
    for (int k = 0; k < tail_len; k++) begin
      if (k == tail_len - QUIET_TAIL) quiet = 1'b1;
      issue_request(pick_request(45, 15), 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;

    while (grant_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
